### sv/kccp_pkg.sv
`default_nettype none
package kccp_pkg;

    localparam int unsigned ARG_SLOTS = 3;

    // opcodes
    localparam logic [7:0] OP_RESET_CMD  = 8'h80;
    localparam logic [7:0] OP_BTN_ACTION = 8'h07;
    localparam logic [7:0] OP_REL_MOUSE  = 8'h08;
    localparam logic [7:0] OP_ABS_MOUSE  = 8'h09;
    localparam logic [7:0] OP_KEY_MOUSE  = 8'h0a;
    localparam logic [7:0] OP_THRESH     = 8'h0b;
    localparam logic [7:0] OP_SCALE      = 8'h0c;
    localparam logic [7:0] OP_LOAD_POS   = 8'h0e;
    localparam logic [7:0] OP_Y_BOTTOM   = 8'h0f;
    localparam logic [7:0] OP_Y_TOP      = 8'h10;
    localparam logic [7:0] OP_RESUME     = 8'h11;
    localparam logic [7:0] OP_PTR_OFF    = 8'h12;
    localparam logic [7:0] OP_PAUSE      = 8'h13;
    localparam logic [7:0] OP_JS_EVENT   = 8'h14;
    localparam logic [7:0] OP_JS_POLL    = 8'h15;
    localparam logic [7:0] OP_JS_WATCH   = 8'h17;
    localparam logic [7:0] OP_FIRE_BTN   = 8'h18;
    localparam logic [7:0] OP_JS_KEYS    = 8'h19;
    localparam logic [7:0] OP_JS_OFF     = 8'h1a;
    localparam logic [7:0] OP_SET_CLOCK  = 8'h1b;
    localparam logic [7:0] OP_MEM_LOAD   = 8'h20;
    localparam logic [7:0] OP_MEM_READ   = 8'h21;
    localparam logic [7:0] OP_EXECUTE    = 8'h22;

    // mode codes
    localparam logic [1:0] PTR_OFF  = 2'd0;
    localparam logic [1:0] PTR_REL  = 2'd1;
    localparam logic [1:0] PTR_ABS  = 2'd2;
    localparam logic [1:0] PTR_KEYS = 2'd3;

    localparam logic [2:0] JS_OFF   = 3'd0;
    localparam logic [2:0] JS_FIRE  = 3'd1;
    localparam logic [2:0] JS_EVENT = 3'd2;
    localparam logic [2:0] JS_POLL  = 3'd3;
    localparam logic [2:0] JS_WATCH = 3'd4;

    typedef logic [ARG_SLOTS-1:0][7:0] t_args;

    typedef struct packed {
        logic [7:0] pending_opcode;
        logic [7:0] bytes_due;
        logic [2:0] arg_index;
        logic       in_data_phase;
    } t_ctl;

    typedef struct packed {
        logic [1:0] ptr_mode;
        logic       button_keys;
        logic [1:0] button_repeat;
        logic [2:0] joystick_mode;
        logic       output_enabled;
        logic       y_origin_top;
        logic [7:0] key_delta_x;
        logic [7:0] key_delta_y;
        logic [7:0] motion_thresh_x;
        logic [7:0] motion_thresh_y;
    } t_modes;

    function automatic logic [7:0] arg_count(input logic [7:0] op);
        logic [7:0] cnt;
        cnt = 8'd0;
        unique case (op) inside
            OP_RESET_CMD, OP_BTN_ACTION, OP_JS_WATCH:               cnt = 8'd1;
            OP_KEY_MOUSE, OP_THRESH, OP_SCALE, OP_MEM_READ, OP_EXECUTE: cnt = 8'd2;
            OP_MEM_LOAD:                                            cnt = 8'd3;
            OP_ABS_MOUSE:                                           cnt = 8'd4;
            OP_LOAD_POS:                                            cnt = 8'd5;
            OP_JS_KEYS, OP_SET_CLOCK:                               cnt = 8'd6;
            default:                                                cnt = 8'd0;
        endcase
        return cnt;
    endfunction

endpackage
`default_nettype wire

### sv/keyboard_controller_command_parser_top.sv
`default_nettype none
// Command parser for an input controller.
// Input channel: one command word per handshake (i_in_valid / o_in_stall,
// payload i_cmd_byte), opcode or argument byte of the pending command.
// Output channel: one result word per command word (o_out_valid /
// i_out_stall): the mode, delta and threshold registers after that word,
// plus o_awaiting_args while argument or data words are still due.
// Path: a word accepted into the input register passes through the step logic
// into the result register, from which the receiver takes it.
// Throughput: one word per cycle while the receiver does not stall; the
// parser state and mode registers are updated from the input register word.
// When the receiver stalls, the result holds and o_in_stall is high in every
// cycle in which a word waits in the input register behind it; no word is
// lost or repeated.
// Reset clears the parser, all modes, deltas and thresholds to zero and
// drops both valids.
module keyboard_controller_command_parser_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_cmd_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [1:0]      o_mouse_mode,
    output logic            o_button_keys,
    output logic [1:0]      o_button_repeat,
    output logic [2:0]      o_joystick_mode,
    output logic            o_output_enabled,
    output logic            o_y_origin_top,
    output logic [7:0]      o_key_delta_x,
    output logic [7:0]      o_key_delta_y,
    output logic [7:0]      o_motion_thresh_x,
    output logic [7:0]      o_motion_thresh_y,
    output logic            o_awaiting_args
);
    import kccp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_ctl       r_ctl;
    t_ctl       n_ctl;
    t_modes     r_modes;
    t_modes     n_modes;
    t_args      r_args;
    t_args      n_args;
    logic       in_fire;
    logic       proc;

    assign proc       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !proc;
    assign in_fire    = i_in_valid && !o_in_stall;

    kccp_step u_step (
        .i_byte  (r_in_byte),
        .i_ctl   (r_ctl),
        .i_modes (r_modes),
        .i_args  (r_args),
        .o_ctl   (n_ctl),
        .o_modes (n_modes),
        .o_args  (n_args)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctl       <= '0;
            r_modes     <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_out_valid <= 1'b1;
                r_ctl       <= n_ctl;
                r_modes     <= n_modes;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_cmd_byte;
        end
        if (proc) begin
            r_args <= n_args;
        end
    end

    // the mode registers double as the result register
    assign o_out_valid       = r_out_valid;
    assign o_mouse_mode      = r_modes.ptr_mode;
    assign o_button_keys     = r_modes.button_keys;
    assign o_button_repeat   = r_modes.button_repeat;
    assign o_joystick_mode   = r_modes.joystick_mode;
    assign o_output_enabled  = r_modes.output_enabled;
    assign o_y_origin_top    = r_modes.y_origin_top;
    assign o_key_delta_x     = r_modes.key_delta_x;
    assign o_key_delta_y     = r_modes.key_delta_y;
    assign o_motion_thresh_x = r_modes.motion_thresh_x;
    assign o_motion_thresh_y = r_modes.motion_thresh_y;
    assign o_awaiting_args   = r_ctl.bytes_due != 8'd0;

    a_data_phase_mem_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.in_data_phase |-> r_ctl.pending_opcode == OP_MEM_LOAD)
        else $error("data phase outside memory load");

    a_idle_index_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.bytes_due == 8'd0 |-> (r_ctl.arg_index == 3'd0 && !r_ctl.in_data_phase))
        else $error("argument index left over after command");

    a_no_watch_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_modes.joystick_mode != JS_WATCH && r_modes.ptr_mode != PTR_ABS)
        else $error("unreachable mode entered");

    a_state_held_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !proc |=> ($stable(r_ctl) && $stable(r_modes)))
        else $error("parser state changed without a word");

endmodule
`default_nettype wire

### sv/kccp_step.sv
`default_nettype none
module kccp_step (
    input  wire logic [7:0]      i_byte,
    input  wire kccp_pkg::t_ctl  i_ctl,
    input  wire kccp_pkg::t_modes i_modes,
    input  wire kccp_pkg::t_args i_args,
    output kccp_pkg::t_ctl       o_ctl,
    output kccp_pkg::t_modes     o_modes,
    output kccp_pkg::t_args      o_args
);
    import kccp_pkg::*;

    logic [7:0] due_m1;

    assign due_m1 = i_ctl.bytes_due - 8'd1;

    always_comb begin
        o_ctl   = i_ctl;
        o_modes = i_modes;
        o_args  = i_args;
        if (i_ctl.bytes_due != 8'd0) begin
            if (!i_ctl.in_data_phase) begin
                if (i_ctl.arg_index < 3'(ARG_SLOTS)) begin
                    o_args[i_ctl.arg_index[1:0]] = i_byte;
                end
                if (i_ctl.arg_index != 3'd7) begin
                    o_ctl.arg_index = i_ctl.arg_index + 3'd1;
                end
            end
            o_ctl.bytes_due = due_m1;
            if (due_m1 == 8'd0) begin
                if (i_ctl.pending_opcode == OP_MEM_LOAD && !i_ctl.in_data_phase
                        && o_args[2] != 8'd0) begin
                    // header done, skip the data words
                    o_ctl.in_data_phase = 1'b1;
                    o_ctl.bytes_due     = o_args[2];
                end else begin
                    o_ctl.in_data_phase = 1'b0;
                    o_ctl.arg_index     = 3'd0;
                    case (i_ctl.pending_opcode)
                        OP_BTN_ACTION: begin
                            if (o_args[0][2]) begin
                                o_modes.button_keys = 1'b1;
                            end else begin
                                o_modes.button_keys   = 1'b0;
                                o_modes.button_repeat = o_args[0][1:0];
                            end
                        end
                        OP_KEY_MOUSE: begin
                            o_modes.ptr_mode    = PTR_KEYS;
                            o_modes.key_delta_x = o_args[0];
                            o_modes.key_delta_y = o_args[1];
                        end
                        OP_THRESH: begin
                            o_modes.motion_thresh_x = o_args[0];
                            o_modes.motion_thresh_y = o_args[1];
                        end
                        default: ;
                    endcase
                end
            end
        end else begin
            o_ctl.pending_opcode = i_byte;
            o_ctl.arg_index      = 3'd0;
            o_ctl.in_data_phase  = 1'b0;
            o_ctl.bytes_due      = arg_count(i_byte);
            unique case (i_byte)
                OP_REL_MOUSE:  o_modes.ptr_mode       = PTR_REL;
                OP_PTR_OFF:    o_modes.ptr_mode       = PTR_OFF;
                OP_Y_BOTTOM:   o_modes.y_origin_top   = 1'b0;
                OP_Y_TOP:      o_modes.y_origin_top   = 1'b1;
                OP_RESUME:     o_modes.output_enabled = 1'b1;
                OP_PAUSE:      o_modes.output_enabled = 1'b0;
                OP_JS_EVENT:   o_modes.joystick_mode  = JS_EVENT;
                OP_JS_POLL:    o_modes.joystick_mode  = JS_POLL;
                OP_FIRE_BTN:   o_modes.joystick_mode  = JS_FIRE;
                OP_JS_OFF:     o_modes.joystick_mode  = JS_OFF;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire
